### sv/covtbl_pkg.sv
// Shared types, codes and constants of the coverage table lookup unit.
package covtbl_pkg;

  localparam int unsigned MaxEntriesDefault = 256;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] FmtList  = 16'd1;
  localparam logic [15:0] FmtRange = 16'd2;

  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeLookup = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORMAT = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_NOT_COVERED = 3'd1,
    ST_MALFORMED   = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LIST   = 2'd1,
    OP_RANGE  = 2'd2,
    OP_UNSUP  = 2'd3
  } op_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  slot;
    logic [15:0] first_glyph;
    logic [15:0] last_glyph;
    logic [15:0] base_index;
    logic [15:0] query_glyph;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] coverage_position;
  } rsp_t;

  typedef struct packed {
    logic [15:0] first_glyph;
    logic [15:0] last_glyph;
    logic [15:0] base_index;
  } entry_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  slot;
    entry_t      entry;
    logic [15:0] glyph;
    logic [15:0] scan_len;
  } cmd_t;

endpackage

### sv/covtbl_if.sv
// Valid/ready channel interface carrying one request or response payload.
interface covtbl_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/covtbl_front.sv
// Front end: configuration registers, request acceptance and classification.
module covtbl_front
  import covtbl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  covtbl_if.sink              req_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_ready_i
);

  logic [15:0] format_q;
  logic [8:0]  count_q;
  logic [15:0] count_ext;
  logic        accept;
  logic        slot_ok;
  req_t        req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FmtList;
      count_q  <= 9'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FORMAT: format_q <= cfg_wdata_i;
        CFG_COUNT:  count_q  <= cfg_wdata_i[8:0];
        default:    format_q <= format_q;
      endcase
    end
  end

  assign req       = req_i.payload;
  assign req_i.ready = cmd_ready_i;
  assign accept    = req_i.valid && cmd_ready_i;
  assign slot_ok   = 16'(req.slot) < 16'(MAX_ENTRIES);
  assign count_ext = 16'(count_q);

  // Loads aimed beyond the store are taken and dropped here.
  assign cmd_valid_o = accept && ((req.mode == ModeLookup) || slot_ok);

  always_comb begin
    cmd_o.slot              = req.slot;
    cmd_o.entry.first_glyph = req.first_glyph;
    cmd_o.entry.last_glyph  = req.last_glyph;
    cmd_o.entry.base_index  = req.base_index;
    cmd_o.glyph             = req.query_glyph;
    cmd_o.scan_len = (count_ext > 16'(MAX_ENTRIES)) ? 16'(MAX_ENTRIES) : count_ext;
    if (req.mode == ModeLoad) begin
      cmd_o.op = OP_LOAD;
    end else if (format_q == FmtList) begin
      cmd_o.op = OP_LIST;
    end else if (format_q == FmtRange) begin
      cmd_o.op = OP_RANGE;
    end else begin
      cmd_o.op = OP_UNSUP;
    end
  end

endmodule

### sv/covtbl_queue.sv
// Short command queue that decouples the front end from the scan engine.
module covtbl_queue
  import covtbl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_data_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            buf_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = buf_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### sv/covtbl_back.sv
// Back end: entry store, sequential coverage scan and response register.
module covtbl_back
  import covtbl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  covtbl_if.source  rsp_o
);

  localparam int unsigned ScanMax = (MAX_ENTRIES < 511) ? MAX_ENTRIES : 511;
  localparam int unsigned CntW    = $clog2(ScanMax + 1);
  localparam int unsigned AddrW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e          state_q, state_d;
  entry_t          mem_q [MAX_ENTRIES];
  entry_t          rdata_q;
  logic            mem_we;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] len_q, len_d;
  logic            vld_q, vld_d;
  logic            range_q, range_d;
  logic [15:0]     glyph_q, glyph_d;
  status_e         stat_q, stat_d;
  logic [15:0]     res_pos_q, res_pos_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;
  logic [15:0]     offset;
  logic [16:0]     range_idx;

  assign offset    = glyph_q - rdata_q.first_glyph;
  assign range_idx = 17'(rdata_q.base_index) + 17'(offset);
  assign mem_we    = (state_q == S_IDLE) && cmd_valid_i && (cmd_i.op == OP_LOAD);
  assign cmd_ready_o = state_q == S_IDLE;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AddrW'(cmd_i.slot)] <= cmd_i.entry;
    end
    rdata_q <= mem_q[AddrW'(rd_idx_q)];
  end

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    pos_d       = pos_q;
    len_d       = len_q;
    vld_d       = vld_q;
    range_d     = range_q;
    glyph_d     = glyph_q;
    stat_d      = stat_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    unique case (state_q)
      S_IDLE: begin
        vld_d     = 1'b0;
        rd_idx_d  = '0;
        res_pos_d = 16'd0;
        len_d     = CntW'(cmd_i.scan_len);
        range_d   = cmd_i.op == OP_RANGE;
        glyph_d   = cmd_i.glyph;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_LOAD: state_d = S_IDLE;
            OP_LIST, OP_RANGE: begin
              if (cmd_i.scan_len == 16'd0) begin
                stat_d  = ST_NOT_COVERED;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_UNSUP: begin
              stat_d  = ST_UNSUPPORTED;
              state_d = S_RESP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_idx_q < len_q) begin
          rd_idx_d = rd_idx_q + 1'b1;
          pos_d    = rd_idx_q;
          vld_d    = 1'b1;
        end else begin
          vld_d = 1'b0;
        end
        if (vld_q) begin
          if (!range_q) begin
            if (rdata_q.first_glyph == glyph_q) begin
              stat_d    = ST_FOUND;
              res_pos_d = 16'(pos_q);
              state_d   = S_RESP;
            end else if (rdata_q.first_glyph > glyph_q) begin
              stat_d  = ST_NOT_COVERED;
              state_d = S_RESP;
            end
          end else begin
            if (rdata_q.first_glyph > rdata_q.last_glyph) begin
              stat_d  = ST_MALFORMED;
              state_d = S_RESP;
            end else if (glyph_q < rdata_q.first_glyph) begin
              stat_d  = ST_NOT_COVERED;
              state_d = S_RESP;
            end else if (glyph_q <= rdata_q.last_glyph) begin
              state_d = S_RESP;
              if (range_idx[16]) begin
                stat_d = ST_OVERFLOW;
              end else begin
                stat_d    = ST_FOUND;
                res_pos_d = range_idx[15:0];
              end
            end
          end
        end else if (rd_idx_q == len_q) begin
          stat_d  = ST_NOT_COVERED;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        vld_d = 1'b0;
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d             = 1'b1;
          out_d.status            = stat_q;
          out_d.coverage_position = res_pos_q;
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    pos_q     <= pos_d;
    len_q     <= len_d;
    range_q   <= range_d;
    glyph_q   <= glyph_d;
    stat_q    <= stat_d;
    res_pos_q <= res_pos_d;
    out_q     <= out_d;
  end

endmodule

### sv/coverage_table_lookup_unit.sv
// Top level of the coverage table lookup unit.
//
// Requests arrive on req_i. A load request (mode 0) writes one entry of the
// store and gives no response; a load to a slot at or above MAX_ENTRIES is
// taken and dropped. A lookup request (mode 1) scans the first entry_count
// entries in order and gives one response on rsp_o with a status and a
// coverage position. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must only do so while the unit is idle (unchecked).
// A load writes its entry in the idle state; the scan engine stays idle. A
// lookup reads the entries in order and stops at the first match, the first
// entry past the glyph, a malformed range or the end of the count; the entry
// store has one read port, so one entry is examined per cycle. An unsupported
// format or an empty table goes straight to the response without a scan. A
// two-entry queue takes further requests while the engine works.
// The response stays in its output register until rsp_o.ready is high; the
// engine and then the queue stall behind it. Reset restores format 1 and an
// entry count of zero; the store contents are undefined until loaded.
module coverage_table_lookup_unit
  import covtbl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  covtbl_if.sink              req_i,
  covtbl_if.source            rsp_o
);

  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  covtbl_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .cmd_valid_o(fq_valid),
    .cmd_o      (fq_cmd),
    .cmd_ready_i(fq_ready)
  );

  covtbl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_data_i (fq_cmd),
    .push_ready_o(fq_ready),
    .pop_valid_o (qb_valid),
    .pop_data_o  (qb_cmd),
    .pop_ready_i (qb_ready)
  );

  covtbl_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(qb_valid),
    .cmd_i      (qb_cmd),
    .cmd_ready_o(qb_ready),
    .rsp_o      (rsp_o)
  );

endmodule
